// ===== hw/rtl/ote_pkg.sv =====
// ---------------------------------------------------------------------------
// ote_pkg: shared types, constants and helpers
// Widths, saturation helpers and divider request/response types used by the
// optimizer trace feature extractor.
// ---------------------------------------------------------------------------
package ote_pkg;

  localparam int CNT_W   = 17;
  localparam int DIV_NW  = 48;
  localparam int DIV_DW  = 32;
  localparam int DIV_CW  = 6;

  localparam logic [CNT_W-1:0] MAX_SAMPLES = 17'd65536;
  localparam logic [15:0]      RUN_COUNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIV_NW-1:0] quot;
  } div_rsp_t;

  // Saturating increment of a sample or run counter.
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v < MAX_SAMPLES) ? v + 1'b1 : v;
  endfunction

endpackage

// ===== hw/rtl/ote_div.sv =====
// ---------------------------------------------------------------------------
// ote_div: radix-2 restoring divider
// Unsigned quotient of a 48-bit numerator by a 32-bit divisor, one quotient
// bit per cycle.
// ---------------------------------------------------------------------------
module ote_div
  import ote_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIV_NW-1:0] num;
  logic [DIV_DW-1:0] den;
  logic [DIV_DW-1:0] rem;
  logic [DIV_CW-1:0] cnt;
  logic              busy;
  logic              done;
  logic [DIV_DW:0]   trial;
  logic              ge;

  // Shift in the next numerator bit and try the subtraction.
  assign trial = {rem, num[DIV_NW-1]};
  assign ge    = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= DIV_CW'(DIV_NW - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num <= req.num;
      den <= req.den;
      rem <= '0;
    end else if (busy) begin
      num <= {num[DIV_NW-2:0], ge};
      rem <= ge ? DIV_DW'(trial - {1'b0, den}) : trial[DIV_DW-1:0];
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quot = num;

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    busy |-> !req.start) else $error("divider restarted while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy) else $error("done without a finished division");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held longer than one cycle");

endmodule

// ===== hw/rtl/optimizer_trace_feature_extractor.sv =====
// ---------------------------------------------------------------------------
// optimizer_trace_feature_extractor: per-sample features of an optimizer trace
// Takes (time, best value) samples of one run and returns gaps, Q15.16
// slopes, plateau lengths and running totals for each sample.
// ---------------------------------------------------------------------------
//
//   channel   signals                                   direction
//   input     in_valid/in_ready, sample_time,           into block
//             incumbent_value, last_sample
//   output    out_valid/out_ready, feature fields       out of block
//   config    psel/penable/pwrite/paddr/pwdata/prdata   APB register port
//
// Each request passes S_MULA and S_MULP, then the single radix-2 divider
// runs, each division a load state, the quotient bits and a done pulse:
// the success ratio alone for the first sample of a run, the consecutive
// slope too for a sample without improvement, and the improvement slope
// too for an improving sample. The next request is taken once the result
// is loaded and the sequencer is idle again. rst is synchronous and clears
// the sequencer, the run state and lower_bound. A new request is taken
// while a finished result still waits in the output register; a stalled
// output only holds the sequencer once its next result is ready.
//
module optimizer_trace_feature_extractor
  import ote_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        sample_time,
  input  logic signed [31:0] incumbent_value,
  input  logic               last_sample,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [32:0] vertical_gap,
  output logic signed [31:0] slope_consecutive,
  output logic signed [31:0] slope_improvement,
  output logic               improved,
  output logic [16:0]        plateau_ended_length,
  output logic signed [63:0] curve_area,
  output logic [15:0]        plateau_count,
  output logic [16:0]        longest_plateau,
  output logic [16:0]        improve_ratio,
  output logic signed [32:0] net_drop,
  output logic               step_valid,
  output logic               run_end,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MULA = 4'd1;
  localparam logic [3:0] S_MULP = 4'd2;
  localparam logic [3:0] S_LD1  = 4'd3;
  localparam logic [3:0] S_DIV1 = 4'd4;
  localparam logic [3:0] S_LD2  = 4'd5;
  localparam logic [3:0] S_DIV2 = 4'd6;
  localparam logic [3:0] S_LD3  = 4'd7;
  localparam logic [3:0] S_DIV3 = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  localparam logic signed [31:0] SLOPE_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SLOPE_MIN = 32'sh8000_0000;
  localparam logic signed [63:0] AREA_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] AREA_MIN  = 64'sh8000_0000_0000_0000;

  // Configuration.
  logic signed [31:0] lower_bound;

  // Run state.
  logic               started;
  logic [31:0]        prev_time;
  logic signed [31:0] prev_value;
  logic signed [31:0] first_value;
  logic [31:0]        improve_time;
  logic signed [31:0] improve_value;
  logic [CNT_W-1:0]   run_length;
  logic [CNT_W-1:0]   max_run;
  logic [15:0]        run_count;
  logic [CNT_W-1:0]   success_total;
  logic [CNT_W-1:0]   sample_total;
  logic signed [63:0] area_sum;

  // Sequencer and the request being worked on.
  logic [3:0]         state;
  logic [3:0]         state_next;
  logic [31:0]        t_r;
  logic signed [31:0] v_r;
  logic               last_r;
  logic [31:0]        mul_a;
  logic [31:0]        mul_b;
  logic               mul_neg;
  logic [63:0]        prod_mag;
  logic signed [31:0] slope_c_r;
  logic signed [31:0] slope_i_r;
  logic [16:0]        ratio_r;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic               in_fire;
  logic               out_load;

  // Step quantities, all taken against the state before this request.
  logic signed [32:0] dt;
  logic signed [32:0] idt;
  logic signed [32:0] gap;
  logic signed [32:0] inum;
  logic signed [32:0] base;
  logic               improved_c;
  logic               equal_c;

  // Finished values.
  logic signed [63:0] prod_sat;
  logic signed [64:0] area_wide;
  logic signed [63:0] area_new;
  logic [CNT_W-1:0]   run_length_new;
  logic [CNT_W-1:0]   max_run_new;
  logic [15:0]        run_count_new;
  logic [CNT_W-1:0]   success_new;
  logic [CNT_W-1:0]   sample_new;
  logic signed [31:0] first_new;
  logic [16:0]        ended_new;
  logic signed [31:0] slope_fix;
  logic               slope_neg;
  logic               slope_num_neg;
  logic               slope_num_zero;
  logic               slope_den_zero;

  function automatic logic [31:0] mag33(input logic signed [32:0] x);
    logic signed [32:0] m;
    m = x[32] ? -x : x;
    mag33 = m[31:0];
  endfunction

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? lower_bound : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      lower_bound <= '0;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      lower_bound <= pwdata;
    end
  end

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_load = (state == S_DONE) && (!out_valid || out_ready);

  assign dt   = $signed({1'b0, t_r}) - $signed({1'b0, prev_time});
  assign idt  = $signed({1'b0, t_r}) - $signed({1'b0, improve_time});
  assign gap  = 33'(v_r) - 33'(prev_value);
  assign inum = 33'(v_r) - 33'(improve_value);
  assign base = 33'(prev_value) - 33'(lower_bound);

  assign improved_c = started && (v_r < prev_value);
  assign equal_c    = (v_r == prev_value);

  // The divider request comes from whichever load state the sequencer is in.
  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = '0;
    div_req.den   = '0;
    case (state)
      S_LD1: begin
        div_req.start = 1'b1;
        div_req.num   = {mag33(gap), 16'd0};
        div_req.den   = mag33(dt);
      end
      S_LD2: begin
        div_req.start = 1'b1;
        div_req.num   = {mag33(inum), 16'd0};
        div_req.den   = mag33(idt);
      end
      S_LD3: begin
        div_req.start = 1'b1;
        div_req.num   = {15'd0, success_new, 16'd0};
        div_req.den   = {15'd0, sample_new};
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  ote_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Sign and saturation of a finished slope quotient. A zero divisor gives
  // the largest magnitude with the sign of the numerator, or zero for a zero numerator.
  always_comb begin
    if (state == S_DIV2) begin
      slope_num_neg  = inum[32];
      slope_num_zero = (inum == '0);
      slope_den_zero = (idt == '0);
      slope_neg      = inum[32] != idt[32];
    end else begin
      slope_num_neg  = gap[32];
      slope_num_zero = (gap == '0);
      slope_den_zero = (dt == '0);
      slope_neg      = gap[32] != dt[32];
    end
    if (slope_den_zero) begin
      slope_fix = slope_num_zero ? 32'sd0 : (slope_num_neg ? SLOPE_MIN : SLOPE_MAX);
    end else if (!slope_neg) begin
      slope_fix = (div_rsp.quot > 48'h0000_7FFF_FFFF) ? SLOPE_MAX
                                                      : $signed(div_rsp.quot[31:0]);
    end else begin
      slope_fix = (div_rsp.quot >= 48'h0000_8000_0000) ? SLOPE_MIN
                                                       : -$signed(div_rsp.quot[31:0]);
    end
  end

  // Next run state and result fields.
  always_comb begin
    if (!mul_neg) begin
      prod_sat = prod_mag[63] ? AREA_MAX : $signed(prod_mag);
    end else begin
      prod_sat = prod_mag[63] ? AREA_MIN : -$signed(prod_mag);
    end
    area_wide = 65'(area_sum) + 65'(prod_sat);
    if (area_wide[64] != area_wide[63]) begin
      area_new = prod_sat[63] ? AREA_MIN : AREA_MAX;
    end else begin
      area_new = area_wide[63:0];
    end

    run_length_new = run_length;
    max_run_new    = max_run;
    run_count_new  = run_count;
    ended_new      = '0;
    success_new    = success_total;
    sample_new     = 17'd1;
    first_new      = v_r;

    if (started) begin
      sample_new = sat_inc(sample_total);
      first_new  = first_value;
      if (improved_c) begin
        success_new = sat_inc(success_total);
      end
      if (equal_c) begin
        run_length_new = sat_inc(run_length);
        if (run_length_new == 17'd2 && run_count != RUN_COUNT_MAX) begin
          run_count_new = run_count + 1'b1;
        end
        if (run_length_new > max_run) begin
          max_run_new = run_length_new;
        end
      end else begin
        if (run_length > 17'd1) begin
          ended_new = run_length;
        end
        run_length_new = 17'd1;
      end
      if (last_r && run_length_new > 17'd1) begin
        ended_new = run_length_new;
      end
    end else begin
      area_new = area_sum;
    end
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_fire) state_next = S_MULA;
      S_MULA: state_next = S_MULP;
      S_MULP: state_next = started ? S_LD1 : S_LD3;
      S_LD1:  state_next = S_DIV1;
      S_DIV1: if (div_rsp.done) state_next = improved_c ? S_LD2 : S_LD3;
      S_LD2:  state_next = S_DIV2;
      S_DIV2: if (div_rsp.done) state_next = S_LD3;
      S_LD3:  state_next = S_DIV3;
      S_DIV3: if (div_rsp.done) state_next = S_DONE;
      S_DONE: if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Request payload and working registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      t_r    <= sample_time;
      v_r    <= incumbent_value;
      last_r <= last_sample;
    end
    if (state == S_MULA) begin
      mul_a   <= mag33(dt);
      mul_b   <= mag33(base);
      mul_neg <= dt[32] != base[32];
    end
    if (state == S_MULP) begin
      prod_mag <= mul_a * mul_b;
    end
    if (state == S_DIV1 && div_rsp.done) begin
      slope_c_r <= slope_fix;
    end
    if (state == S_DIV2 && div_rsp.done) begin
      slope_i_r <= slope_fix;
    end
    if (state == S_DIV3 && div_rsp.done) begin
      ratio_r <= div_rsp.quot[16:0];
    end
  end

  // Run state; the last sample of a run returns it to its cleared values.
  always_ff @(posedge clk) begin
    if (rst || (out_load && last_r)) begin
      started       <= 1'b0;
      prev_time     <= '0;
      prev_value    <= '0;
      first_value   <= '0;
      improve_time  <= '0;
      improve_value <= '0;
      run_length    <= 17'd1;
      max_run       <= 17'd1;
      run_count     <= '0;
      success_total <= '0;
      sample_total  <= '0;
      area_sum      <= '0;
    end else if (out_load) begin
      started       <= 1'b1;
      prev_time     <= t_r;
      prev_value    <= v_r;
      first_value   <= first_new;
      if (!started || improved_c) begin
        improve_time  <= t_r;
        improve_value <= v_r;
      end
      run_length    <= run_length_new;
      max_run       <= max_run_new;
      run_count     <= run_count_new;
      success_total <= success_new;
      sample_total  <= sample_new;
      area_sum      <= area_new;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      vertical_gap         <= started ? gap : 33'sd0;
      slope_consecutive    <= started ? slope_c_r : 32'sd0;
      slope_improvement    <= improved_c ? slope_i_r : 32'sd0;
      improved             <= improved_c;
      plateau_ended_length <= ended_new;
      curve_area           <= area_new;
      plateau_count        <= run_count_new;
      longest_plateau      <= max_run_new;
      improve_ratio        <= ratio_r;
      net_drop             <= 33'(first_new) - 33'(v_r);
      step_valid           <= started;
      run_end              <= last_r;
    end
  end

  a_busy_only_working: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !div_rsp.busy) else $error("divider busy while idle");
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> state == S_MULA) else $error("accepted request did not start");
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (out_load && last_r) |=> !started && area_sum == 64'sd0)
    else $error("run state not cleared after last sample");
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_DIV1 || state == S_DIV2 || state == S_DIV3))
    else $error("division finished outside a divide state");

endmodule

// ===== test/trace_feature_checker.sv =====
// ---------------------------------------------------------------------------
// trace_feature_checker: scoreboard for the trace feature extractor
// Watches the request, result and register channels and predicts the
// features of every accepted request. Each result is compared field by
// field with the oldest prediction.
// ---------------------------------------------------------------------------
module trace_feature_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [31:0]        sample_time,
  input  logic signed [31:0] incumbent_value,
  input  logic               last_sample,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [32:0] vertical_gap,
  input  logic signed [31:0] slope_consecutive,
  input  logic signed [31:0] slope_improvement,
  input  logic               improved,
  input  logic [16:0]        plateau_ended_length,
  input  logic signed [63:0] curve_area,
  input  logic [15:0]        plateau_count,
  input  logic [16:0]        longest_plateau,
  input  logic [16:0]        improve_ratio,
  input  logic signed [32:0] net_drop,
  input  logic               step_valid,
  input  logic               run_end,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output int                 mismatches,
  output int                 pending
);

  localparam logic [2:0] ADDR_LOWER_BOUND = 3'd0;
  localparam longint     Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint     Q_MIN = -64'sh7FFF_FFFF_FFFF_FFFF - 1;
  localparam int unsigned SAMPLE_CAP = 65536;

  typedef struct packed {
    logic signed [32:0] gap;
    logic signed [31:0] s_cons;
    logic signed [31:0] s_imp;
    logic               imp;
    logic [16:0]        ended;
    logic signed [63:0] area;
    logic [15:0]        pcount;
    logic [16:0]        longest;
    logic [16:0]        ratio;
    logic signed [32:0] total;
    logic               valid;
    logic               last;
  } features_t;

  features_t expected_features[$];

  longint      lower_bound;
  bit          running;
  logic [31:0] prev_t, imp_t;
  longint      prev_v, first_v, imp_v, area;
  int unsigned run_len, max_run, run_cnt, succ, samples;

  function automatic longint q16_slope(longint num, longint den);
    bit         neg;
    logic [63:0] mn, md, q;
    neg = (num < 0) != (den < 0);
    mn = 64'(num < 0 ? -num : num) << 16;
    md = 64'(den < 0 ? -den : den);
    if (den == 0) return (num > 0) ? 64'sh7FFF_FFFF : (num < 0) ? -64'sh8000_0000 : 0;
    q = mn / md;
    if (!neg) return (q > 64'h7FFF_FFFF) ? 64'sh7FFF_FFFF : longint'(q);
    return (q >= 64'h8000_0000) ? -64'sh8000_0000 : -longint'(q);
  endfunction

  function automatic longint sat_mul(longint a, longint b);
    logic signed [127:0] p;
    p = 128'(a) * 128'(b);
    if (p > Q_MAX) return Q_MAX;
    if (p < Q_MIN) return Q_MIN;
    return longint'(p);
  endfunction

  function automatic longint sat_add(longint a, longint b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > Q_MAX) return Q_MAX;
    if (s < Q_MIN) return Q_MIN;
    return longint'(s);
  endfunction

  function automatic int unsigned sat_inc(int unsigned v);
    return (v < SAMPLE_CAP) ? v + 1 : v;
  endfunction

  task automatic clear_run();
    running = 0;
    prev_t = '0;
    imp_t = '0;
    prev_v = 0;
    first_v = 0;
    imp_v = 0;
    area = 0;
    run_len = 1;
    max_run = 1;
    run_cnt = 0;
    succ = 0;
    samples = 0;
  endtask

  task automatic predict_features(logic [31:0] t, logic signed [31:0] value, logic last);
    features_t f;
    longint    v, dt;
    f = '0;
    v = longint'(value);
    if (!running) begin
      running = 1;
      first_v = v;
      imp_t = t;
      imp_v = v;
      samples = 1;
    end else begin
      dt = longint'(t) - longint'(prev_t);
      f.valid = 1;
      f.gap = 33'(v - prev_v);
      samples = sat_inc(samples);
      area = sat_add(area, sat_mul(dt, prev_v - lower_bound));
      if (v < prev_v) begin
        f.imp = 1;
        succ = sat_inc(succ);
        f.s_imp = 32'(q16_slope(v - imp_v, longint'(t) - longint'(imp_t)));
        imp_t = t;
        imp_v = v;
      end
      f.s_cons = 32'(q16_slope(v - prev_v, dt));
      if (v == prev_v) begin
        run_len = sat_inc(run_len);
        if (run_len == 2 && run_cnt < 65535) run_cnt++;
        if (run_len > max_run) max_run = run_len;
      end else begin
        if (run_len > 1) f.ended = 17'(run_len);
        run_len = 1;
      end
      if (last && run_len > 1) f.ended = 17'(run_len);
    end
    prev_t = t;
    prev_v = v;
    f.area = area;
    f.pcount = 16'(run_cnt);
    f.longest = 17'(max_run);
    f.ratio = samples ? 17'((longint'(succ) << 16) / samples) : '0;
    f.total = 33'(first_v - v);
    f.last = last;
    expected_features.push_back(f);
    if (last) clear_run();
  endtask

  task automatic report(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, field, got, want);
    mismatches++;
  endtask

  task automatic compare_features();
    features_t w;
    if (expected_features.size() == 0) begin
      report("unexpected result", 64'(vertical_gap), '0);
      return;
    end
    w = expected_features.pop_front();
    if (vertical_gap !== w.gap) report("vertical_gap", 64'(vertical_gap), 64'(w.gap));
    if (slope_consecutive !== w.s_cons)
      report("slope_consecutive", 64'(slope_consecutive), 64'(w.s_cons));
    if (improved !== w.imp) report("improved", 64'(improved), 64'(w.imp));
    // The improvement slope only carries meaning on an improving step.
    if (w.imp && slope_improvement !== w.s_imp)
      report("slope_improvement", 64'(slope_improvement), 64'(w.s_imp));
    if (plateau_ended_length !== w.ended)
      report("plateau_ended_length", 64'(plateau_ended_length), 64'(w.ended));
    if (curve_area !== w.area) report("curve_area", curve_area, w.area);
    if (plateau_count !== w.pcount) report("plateau_count", 64'(plateau_count), 64'(w.pcount));
    if (longest_plateau !== w.longest)
      report("longest_plateau", 64'(longest_plateau), 64'(w.longest));
    if (improve_ratio !== w.ratio) report("improve_ratio", 64'(improve_ratio), 64'(w.ratio));
    if (net_drop !== w.total)
      report("net_drop", 64'(net_drop), 64'(w.total));
    if (step_valid !== w.valid) report("step_valid", 64'(step_valid), 64'(w.valid));
    if (run_end !== w.last) report("run_end", 64'(run_end), 64'(w.last));
  endtask

  initial begin
    mismatches = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      lower_bound = 0;
      clear_run();
      expected_features.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == ADDR_LOWER_BOUND)
        lower_bound = longint'($signed(pwdata));
      if (in_valid && in_ready) predict_features(sample_time, incumbent_value, last_sample);
      if (out_valid && out_ready) compare_features();
    end
    pending = expected_features.size();
  end

endmodule

// ===== test/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top: regression for optimizer_trace_feature_extractor
// Drives runs of (time, value) samples with random gaps and output stalls,
// moves lower_bound through several settings, and leaves all checking to
// the scoreboard that sits beside the block.
// ---------------------------------------------------------------------------
module tb_top;

  localparam logic [2:0] ADDR_LOWER_BOUND = 3'd0;
  localparam int         IDLE_PCT = 12;

  logic               clk, rst;
  logic               in_valid, in_ready, last_sample;
  logic [31:0]        sample_time;
  logic signed [31:0] incumbent_value;
  logic               out_valid, out_ready;
  logic signed [32:0] vertical_gap, net_drop;
  logic signed [31:0] slope_consecutive, slope_improvement;
  logic               improved, step_valid, run_end;
  logic [16:0]        plateau_ended_length, longest_plateau, improve_ratio;
  logic signed [63:0] curve_area;
  logic [15:0]        plateau_count;
  logic               psel, penable, pwrite, pready;
  logic [2:0]         paddr;
  logic [31:0]        pwdata, prdata;
  int                 mismatches, pending;

  // When quiet is set neither side idles. stall_cycles asks the receiver
  // for one long hold-off, which it counts down on its own.
  bit                 quiet;
  int                 stall_cycles;
  logic [31:0]        trace_time;
  logic signed [31:0] trace_value;

  optimizer_trace_feature_extractor u_top (.*);

  trace_feature_checker u_checker (.*);

  initial clk = 0;

  always #4 clk = ~clk;

  // Run limit, far beyond the slowest correct run.
  initial begin
    #(8 * 4_000_000);
    $display("optimizer_trace_feature_extractor regression: fail");
    $finish;
  end

  // Receiver: random back-pressure plus the requested long hold-off.
  initial begin
    out_ready = 0;
    stall_cycles = 0;
    forever begin
      @(negedge clk);
      if (stall_cycles > 0) begin
        stall_cycles--;
        out_ready <= 0;
      end else begin
        out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // One sample request. Valid stays high into the next request unless a
  // random gap is taken, so back-to-back offers happen as well.
  task automatic send_sample(logic [31:0] t, logic signed [31:0] v, logic last);
    int gap_len;
    if (!quiet && $urandom_range(99) < IDLE_PCT) begin
      gap_len = $urandom_range(6, 1);
      in_valid <= 0;
      repeat (gap_len) @(negedge clk);
    end
    in_valid <= 1;
    sample_time <= t;
    incumbent_value <= v;
    last_sample <= last;
    do @(posedge clk); while (!(in_valid && in_ready));
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
  endtask

  // Register writes happen only with nothing in flight.
  task automatic write_lower_bound(logic [31:0] value);
    drain();
    psel <= 1;
    pwrite <= 1;
    penable <= 0;
    paddr <= ADDR_LOWER_BOUND;
    pwdata <= value;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
  endtask

  // One run of the trace. Most runs look like a real optimizer: time rises,
  // the value falls or sits on a plateau. Some steps are noise: rising
  // values, repeated or falling times, and full-range jumps.
  task automatic send_run(int len);
    logic [31:0]        step;
    logic signed [31:0] drop;
    int                 kind;
    if ($urandom_range(3) == 0) begin
      trace_time = $urandom;
      trace_value = $urandom;
    end else begin
      trace_time = $urandom_range(1000);
      trace_value = $urandom_range(100000);
    end
    for (int i = 0; i < len; i++) begin
      send_sample(trace_time, trace_value, i == len - 1);
      kind = $urandom_range(99);
      step = (kind % 7 == 0) ? 32'd0 : $urandom_range(50, 1);
      drop = $urandom_range(500, 1);
      if (kind < 35) begin
        trace_time += step;
      end else if (kind < 75) begin
        trace_time += step;
        trace_value -= drop;
      end else if (kind < 85) begin
        trace_time += step;
        trace_value += drop;
      end else if (kind < 92) begin
        trace_time -= step;
        trace_value -= drop;
      end else begin
        trace_time = $urandom;
        trace_value = $urandom;
      end
    end
  endtask

  initial begin
    rst = 1;
    quiet = 0;
    in_valid = 0;
    sample_time = '0;
    incumbent_value = '0;
    last_sample = 0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = '0;
    pwdata = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed part: single-sample run, zero time differences, extreme
    // values, decreasing time and a plateau left open at the run end.
    write_lower_bound(32'd0);
    send_sample(32'd5, 32'sd100, 1);
    send_sample(32'd0, 32'sh7FFF_FFFF, 0);
    send_sample(32'd0, 32'sh7FFF_FFFF, 0);
    send_sample(32'd0, -32'sh8000_0000, 0);
    send_sample(32'hFFFF_FFFF, -32'sh8000_0000, 0);
    send_sample(32'hFFFF_FFFF, 32'sh7FFF_FFFF, 0);
    send_sample(32'd10, 32'sh7FFF_FFFF, 0);
    send_sample(32'd3, 32'sd7, 0);
    send_sample(32'd3, 32'sd7, 1);

    // Area saturation upward, then downward with the opposite bound.
    write_lower_bound(32'h8000_0000);
    send_sample(32'd0, 32'sh7FFF_FFFF, 0);
    send_sample(32'hFFFF_FFFF, 32'sh7FFF_FFFF, 0);
    send_sample(32'hFFFF_FFFF, 32'sd0, 0);
    send_sample(32'd0, -32'sd1, 1);
    write_lower_bound(32'h7FFF_FFFF);
    send_sample(32'd0, -32'sh8000_0000, 0);
    send_sample(32'hFFFF_FFFF, -32'sh8000_0000, 0);
    send_sample(32'hFFFF_FFFF, -32'sh8000_0000, 1);

    // Random part in phases, each under its own lower bound. The second
    // phase runs with no idling and a long receiver hold-off that lets the
    // block fill up and stall its input.
    for (int phase = 0; phase < 6; phase++) begin
      write_lower_bound(phase == 0 ? 32'd0 : $urandom);
      quiet = (phase == 1);
      if (phase == 1) stall_cycles = 800;
      for (int n = 0; n < 205; ) begin
        automatic int len = ($urandom_range(9) == 0) ? $urandom_range(60, 20)
                                                    : $urandom_range(12, 1);
        if (n + len > 205) len = 205 - n;
        send_run(len);
        n += len;
      end
      quiet = 0;
    end

    drain();
    repeat (400) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("optimizer_trace_feature_extractor regression: pass");
    end else begin
      $display("optimizer_trace_feature_extractor regression: fail");
    end
    $finish;
  end

endmodule
